// ----- hdl/ssb_pkg.sv -----
// ----------------------------------------------------------------------------
// ssb_pkg
// Types, constants and the basis table for the spline segment to Bezier block.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int OUT_WIDTH       = 20;
  // worst row of the basis sums to 34 in magnitude, so six bits of growth
  localparam int SUM_WIDTH       = COORD_WIDTH + 6;
  localparam int COUNT_WIDTH     = 10;
  localparam int MODE_WIDTH      = 2;
  localparam int COEF_WIDTH      = 6;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 10;
  localparam int CMP_WIDTH       = (SUM_WIDTH > OUT_WIDTH ? SUM_WIDTH : OUT_WIDTH) + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_WIDTH-1:0]   out_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic [CFG_INDEX_WIDTH-1:0]    cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0]     cfg_data_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;
  typedef logic [MODE_WIDTH-1:0]         mode_t;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_BEZIER  = 2'd0,
    MODE_INTERP  = 2'd1,
    MODE_BSPLINE = 2'd2
  } curve_mode_t;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CURVE_MODE = 1'b0,
    REG_MAX_POINTS = 1'b1
  } cfg_reg_t;

  localparam count_t MAX_POINTS_RESET = COUNT_WIDTH'(25);

  // basis matrices in sixths, [mode][output row][window point]
  localparam coef_t BASIS [3][4][4] = '{
    '{ '{6, 0, 0, 0}, '{0, 6, 0, 0}, '{0, 0, 6, 0}, '{0, 0, 0, 6} },
    '{ '{6, 0, 0, 0}, '{-5, 18, -9, 2}, '{2, -9, 18, -5}, '{0, 0, 0, 6} },
    '{ '{1, 4, 1, 0}, '{0, 4, 2, 0}, '{0, 2, 4, 0}, '{0, 1, 4, 1} }
  };

  // floor(2^SUM_WIDTH / 6): quotient estimate is exact or one low
  localparam logic [SUM_WIDTH-1:0] DIV6_RECIP = SUM_WIDTH'((64'd1 << SUM_WIDTH) / 6);
  localparam logic [CMP_WIDTH-1:0] POS_LIMIT  = CMP_WIDTH'((64'd1 << (OUT_WIDTH-1)) - 1);
  localparam logic [CMP_WIDTH-1:0] NEG_LIMIT  = CMP_WIDTH'(64'd1 << (OUT_WIDTH-1));
  localparam out_t OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam out_t OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  // divide by 6, ties away from zero, then saturate to the output range
  function automatic out_t div6_round_sat(input sum_t s);
    logic                   neg;
    logic [SUM_WIDTH-1:0]   mag;
    logic [2*SUM_WIDTH-1:0] prod;
    logic [SUM_WIDTH-1:0]   q0;
    logic [SUM_WIDTH-1:0]   rem;
    logic [SUM_WIDTH-1:0]   q;
    logic [CMP_WIDTH-1:0]   qw;
    out_t                   res;
    neg  = s[SUM_WIDTH-1];
    mag  = neg ? SUM_WIDTH'(-s) : SUM_WIDTH'(s);
    mag  = mag + SUM_WIDTH'(3);
    prod = (2*SUM_WIDTH)'(mag) * (2*SUM_WIDTH)'(DIV6_RECIP);
    q0   = prod[2*SUM_WIDTH-1:SUM_WIDTH];
    rem  = mag - SUM_WIDTH'(q0 * SUM_WIDTH'(6));
    q    = q0 + SUM_WIDTH'(rem >= SUM_WIDTH'(6));
    qw   = CMP_WIDTH'(q);
    if (!neg && qw > POS_LIMIT) begin
      res = OUT_MAX;
    end else if (neg && qw > NEG_LIMIT) begin
      res = OUT_MIN;
    end else if (neg) begin
      res = -OUT_WIDTH'(q);
    end else begin
      res = OUT_WIDTH'(q);
    end
    return res;
  endfunction

endpackage

// ----- hdl/spline_segment_to_bezier.sv -----
// ----------------------------------------------------------------------------
// spline_segment_to_bezier
// Converts a stream of spline control points into Bezier segments.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_stall  | op, in_x, in_y, in_z
//  out     | out_valid / out_stall| out_x, out_y, out_z, seg_last
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A point that completes a segment loads four words into the result buffer;
//  they leave one per cycle through the output register while out_stall
//  is low, and the input stalls meanwhile. Other words (clear, ignored add,
//  no segment) leave the buffer empty. The next word is taken in the cycle
//  the last buffered result moves out. Reset clears count, phase, buffer and
//  output valid; the window of points and the result payload are not reset.
// ----------------------------------------------------------------------------
module spline_segment_to_bezier (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  ssb_pkg::coord_t     in_x,
  input  ssb_pkg::coord_t     in_y,
  input  ssb_pkg::coord_t     in_z,
  output logic                out_valid,
  input  logic                out_stall,
  output ssb_pkg::out_t       out_x,
  output ssb_pkg::out_t       out_y,
  output ssb_pkg::out_t       out_z,
  output logic                seg_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ssb_pkg::cfg_index_t cfg_index,
  input  ssb_pkg::cfg_data_t  cfg_data
);
  import ssb_pkg::*;

  mode_t      curve_mode;
  count_t     max_points;
  count_t     point_count;
  logic [1:0] step_phase;
  logic [2:0] remain;
  logic [1:0] rd_idx;

  coord_t     win [3][3];
  sum_t       sums [4][3];
  sum_t       sums_next [4][3];
  coord_t     pt [3];
  coord_t     cur [4][3];
  mode_t      tbl_mode;

  logic in_accept;
  logic add_acc;
  logic have_window;
  logic emit;
  logic load;

  assign cfg_ready   = 1'b1;
  assign in_accept   = in_valid && !in_stall;
  assign add_acc     = in_accept && (op == OP_ADD) && (point_count < max_points);
  assign have_window = point_count >= COUNT_WIDTH'(3);
  assign emit        = add_acc && have_window &&
                       (curve_mode == MODE_BSPLINE || step_phase == 2'd0);
  assign load        = (remain != 3'd0) && (!out_valid || !out_stall);
  assign in_stall    = !((remain == 3'd0) || (remain == 3'd1 && load));

  // unused mode code 3 uses the identity basis
  assign tbl_mode = (curve_mode == MODE_INTERP || curve_mode == MODE_BSPLINE) ?
                    curve_mode : MODE_BEZIER;

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cur[0][j] = win[0][j];
      cur[1][j] = win[1][j];
      cur[2][j] = win[2][j];
      cur[3][j] = pt[j];
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 3; j++) begin
        sums_next[r][j] = '0;
        for (int k = 0; k < 4; k++) begin
          sums_next[r][j] = sums_next[r][j] +
                            sum_t'(BASIS[tbl_mode][r][k]) * sum_t'(cur[k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode  <= MODE_BEZIER;
      max_points  <= MAX_POINTS_RESET;
      point_count <= '0;
      step_phase  <= '0;
      remain      <= '0;
      rd_idx      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CURVE_MODE: curve_mode <= cfg_data[MODE_WIDTH-1:0];
          REG_MAX_POINTS: max_points <= cfg_data[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_accept && op == OP_CLEAR) begin
        point_count <= '0;
        step_phase  <= '0;
      end else if (add_acc) begin
        point_count <= point_count + COUNT_WIDTH'(1);
        if (have_window) begin
          step_phase <= (step_phase == 2'd2) ? 2'd0 : step_phase + 2'd1;
        end
      end
      if (emit) begin
        remain <= 3'd4;
        rd_idx <= 2'd0;
      end else if (load) begin
        remain <= remain - 3'd1;
        rd_idx <= rd_idx + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_acc) begin
      for (int j = 0; j < 3; j++) begin
        win[0][j] <= win[1][j];
        win[1][j] <= win[2][j];
        win[2][j] <= pt[j];
      end
    end
    if (emit) begin
      sums <= sums_next;
    end
    if (load) begin
      out_x    <= div6_round_sat(sums[rd_idx][0]);
      out_y    <= div6_round_sat(sums[rd_idx][1]);
      out_z    <= div6_round_sat(sums[rd_idx][2]);
      seg_last <= (rd_idx == 2'd3);
    end
  end

`ifndef SYNTH
  // a new segment refills the buffer with all four words
  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    emit |=> (remain == 3'd4 && rd_idx == 2'd0))
    else $error("segment did not load four results");

  // the word that empties the buffer is the segment's last one
  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    (load && remain == 3'd1) |=> (out_valid && seg_last))
    else $error("last result of segment not flagged");

  // buffer count and read index stay in step
  a_idx_count: assert property (@(posedge clk) disable iff (rst)
    (remain != 3'd0) |-> (3'(rd_idx) + remain == 3'd4))
    else $error("result buffer index out of step");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    step_phase != 2'd3)
    else $error("segment phase out of range");
`endif

endmodule
